@@ hw/rtl/ssc_pkg.sv @@
// ----------------------------------------------------------------------------
// ssc_pkg - shared types, constants and band tables
// Measurement, configuration and charger status types, register indexes and
// the duty and power band lookups.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CfgAutoEnable   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCarCtrl      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCarStartW    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCarStopW     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgS1RestMs     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgS2RestMs     = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgCarGapMs     = 3'd6;

  localparam logic [9:0] DutyMax = 10'd1023;

  localparam logic [9:0] DutyBand [11] = '{
    10'd0, 10'd120, 10'd220, 10'd320, 10'd420, 10'd520,
    10'd620, 10'd720, 10'd820, 10'd920, 10'd980
  };
  localparam logic [9:0] PowLim [11] = '{
    10'd50, 10'd100, 10'd200, 10'd300, 10'd400, 10'd500,
    10'd600, 10'd700, 10'd800, 10'd900, 10'd950
  };
  localparam logic [9:0] PowVal [12] = '{
    10'd0, 10'd100, 10'd150, 10'd200, 10'd250, 10'd300,
    10'd350, 10'd400, 10'd450, 10'd500, 10'd550, 10'd600
  };

  typedef struct packed {
    logic signed [15:0] net_power;
    logic [31:0]        time_ms;
  } ssc_meas_t;

  typedef struct packed {
    logic               auto_enable;
    logic               car_ctrl_enable;
    logic signed [15:0] car_start_watts;
    logic signed [15:0] car_stop_watts;
    logic [31:0]        s1_rest_ms;
    logic [31:0]        s2_rest_ms;
    logic [31:0]        car_gap_ms;
  } ssc_cfg_t;

  // charger state as held before the current step
  typedef struct packed {
    logic       fixed_on;
    logic       regulated_on;
    logic [9:0] duty;
  } ssc_chg_status_t;

  // regulated charger power estimate from the duty
  function automatic logic [9:0] regulated_power(input logic [9:0] duty);
    logic [9:0] r;
    r = PowVal[11];
    for (int i = 10; i >= 0; i--) begin
      if (duty < PowLim[i]) r = PowVal[i];
    end
    return r;
  endfunction

  // s is twice the net power plus the current duty
  function automatic logic [9:0] duty_lookup(input logic signed [18:0] s);
    logic [9:0] r;
    r = DutyMax;
    for (int i = 10; i >= 0; i--) begin
      if (s < $signed(19'(100 * (i + 1)))) r = DutyBand[i];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/ssc_car.sv @@
// ----------------------------------------------------------------------------
// ssc_car - car charge request logic
// Sample counters, hold-off timing and start/stop pulses for car charging.
// ----------------------------------------------------------------------------
module ssc_car (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  ssc_pkg::ssc_meas_t       meas_i,
  input  ssc_pkg::ssc_cfg_t        cfg_i,
  input  ssc_pkg::ssc_chg_status_t chg_i,
  output logic                     start_req_o,
  output logic                     stop_req_o
);
  import ssc_pkg::*;

  logic [31:0] last_sw_q, last_sw_d;
  logic        charging_q, charging_d;
  logic [3:0]  high_cnt_q, high_cnt_d;
  logic [3:0]  low_cnt_q, low_cnt_d;
  logic [31:0] now_off;
  logic        gap_ok;
  logic        high_cond;

  assign now_off   = meas_i.time_ms + cfg_i.car_gap_ms;
  assign gap_ok    = (now_off - last_sw_q) > cfg_i.car_gap_ms;
  assign high_cond = chg_i.fixed_on && chg_i.regulated_on && (chg_i.duty == DutyMax)
                     && (meas_i.net_power > cfg_i.car_start_watts) && !charging_q;

  always_comb begin
    last_sw_d   = last_sw_q;
    charging_d  = charging_q;
    high_cnt_d  = high_cnt_q;
    low_cnt_d   = low_cnt_q;
    start_req_o = 1'b0;
    stop_req_o  = 1'b0;
    if (gap_ok) begin
      if (high_cond) begin
        if (high_cnt_q >= 4'd10 && cfg_i.car_ctrl_enable) begin
          start_req_o = 1'b1;
          last_sw_d   = now_off;
          charging_d  = 1'b1;
          high_cnt_d  = '0;
        end else if (high_cnt_q != 4'd15) begin
          high_cnt_d = high_cnt_q + 4'd1;
        end
      end else if ((meas_i.net_power < cfg_i.car_stop_watts) && charging_q
                   && cfg_i.car_ctrl_enable) begin
        if (low_cnt_q >= 4'd10) begin
          stop_req_o = 1'b1;
          last_sw_d  = now_off;
          charging_d = 1'b0;
          low_cnt_d  = '0;
        end else begin
          low_cnt_d = low_cnt_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_sw_q  <= '0;
      charging_q <= 1'b0;
      high_cnt_q <= '0;
      low_cnt_q  <= '0;
    end else if (step_i) begin
      last_sw_q  <= last_sw_d;
      charging_q <= charging_d;
      high_cnt_q <= high_cnt_d;
      low_cnt_q  <= low_cnt_d;
    end
  end

endmodule

@@ hw/rtl/ssc_charge.sv @@
// ----------------------------------------------------------------------------
// ssc_charge - charger switching and duty
// Fixed and regulated charger state, switch timers, low-surplus and
// excess-wait timers, and the regulated charger duty.
// ----------------------------------------------------------------------------
module ssc_charge (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  ssc_pkg::ssc_meas_t       meas_i,
  input  ssc_pkg::ssc_cfg_t        cfg_i,
  output ssc_pkg::ssc_chg_status_t stat_o,
  output ssc_pkg::ssc_chg_status_t next_o,
  output logic                     written_o
);
  import ssc_pkg::*;

  logic        s1_q, s1_d, s2_q, s2_d;
  logic [9:0]  duty_q, duty_d;
  logic        fs_vld_q, fs_vld_d, rs_vld_q, rs_vld_d;
  logic [31:0] fs_time_q, fs_time_d, rs_time_q, rs_time_d;
  logic        fl_vld_q, fl_vld_d, rl_vld_q, rl_vld_d, ew_vld_q, ew_vld_d;
  logic [31:0] fl_start_q, fl_start_d, rl_start_q, rl_start_d;
  logic [31:0] ew_start_q, ew_start_d;

  logic [31:0]        now;
  logic signed [16:0] n0, n1;
  logic signed [17:0] avail;
  logic signed [18:0] duty_sum;
  logic               done;

  assign now   = meas_i.time_ms;
  assign n0    = {meas_i.net_power[15], meas_i.net_power};
  assign avail = {{2{meas_i.net_power[15]}}, meas_i.net_power}
                 + (s2_q ? {8'b0, regulated_power(duty_q)} : 18'sd0);

  always_comb begin
    s1_d = s1_q;  s2_d = s2_q;  duty_d = duty_q;
    fs_vld_d = fs_vld_q;  fs_time_d = fs_time_q;
    rs_vld_d = rs_vld_q;  rs_time_d = rs_time_q;
    fl_vld_d = fl_vld_q;  fl_start_d = fl_start_q;
    rl_vld_d = rl_vld_q;  rl_start_d = rl_start_q;
    ew_vld_d = ew_vld_q;  ew_start_d = ew_start_q;
    n1 = n0;
    done = 1'b0;
    written_o = 1'b0;

    if (cfg_i.auto_enable) begin
      if ((!s1_q && n0 > 17'sd600) || (s1_q && n0 > 17'sd0)) fl_vld_d = 1'b0;
      if (!fs_vld_q || (now - fs_time_q) > cfg_i.s1_rest_ms) begin
        if (!s1_q) begin
          if (avail > 18'sd600) begin
            if (!ew_vld_q) begin
              ew_vld_d   = 1'b1;
              ew_start_d = now;
            end
            if ((now - ew_start_d) > 32'd60000) begin
              n1 = n0 - 17'sd600;
              s1_d = 1'b1;
              fs_vld_d = 1'b1;
              fs_time_d = now;
              done = s2_q;
            end
          end else begin
            ew_vld_d = 1'b0;
          end
        end else if (n0 < -17'sd300) begin
          if (!fl_vld_d) begin
            fl_vld_d   = 1'b1;
            fl_start_d = now;
          end
          if ((now - fl_start_d) > 32'd60000) begin
            n1 = n0 + 17'sd600;
            s1_d = 1'b0;
            ew_vld_d = 1'b0;
            fs_vld_d = 1'b1;
            fs_time_d = now;
          end
        end
      end

      if (!done) begin
        if (n1 > 17'sd0) rl_vld_d = 1'b0;
        if (!rs_vld_q || (now - rs_time_q) > cfg_i.s2_rest_ms) begin
          if (!s2_q) begin
            if (n1 > 17'sd30) begin
              s2_d = 1'b1;
              rs_vld_d = 1'b1;
              rs_time_d = now;
              done = 1'b1;
            end
          end else if (n1 < -17'sd100) begin
            if (!rl_vld_d) begin
              rl_vld_d   = 1'b1;
              rl_start_d = now;
            end
            if ((now - rl_start_d) > 32'd300000) begin
              s2_d = 1'b0;
              rs_vld_d = 1'b1;
              rs_time_d = now;
            end
          end
        end
      end
    end

    duty_sum = $signed({n1[16], n1, 1'b0}) + $signed({9'b0, duty_q});
    if (!done && s2_d) begin
      duty_d = duty_lookup(duty_sum);
      written_o = 1'b1;
    end
  end

  assign stat_o = '{fixed_on: s1_q, regulated_on: s2_q, duty: duty_q};
  assign next_o = '{fixed_on: s1_d, regulated_on: s2_d, duty: duty_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q     <= 1'b0;
      s2_q     <= 1'b0;
      duty_q   <= '0;
      fs_vld_q <= 1'b0;
      rs_vld_q <= 1'b0;
      fl_vld_q <= 1'b0;
      rl_vld_q <= 1'b0;
      ew_vld_q <= 1'b0;
    end else if (step_i) begin
      s1_q     <= s1_d;
      s2_q     <= s2_d;
      duty_q   <= duty_d;
      fs_vld_q <= fs_vld_d;
      rs_vld_q <= rs_vld_d;
      fl_vld_q <= fl_vld_d;
      rl_vld_q <= rl_vld_d;
      ew_vld_q <= ew_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      fs_time_q  <= fs_time_d;
      rs_time_q  <= rs_time_d;
      fl_start_q <= fl_start_d;
      rl_start_q <= rl_start_d;
      ew_start_q <= ew_start_d;
    end
  end

endmodule

@@ hw/rtl/solar_surplus_charger_switch.sv @@
// ----------------------------------------------------------------------------
// solar_surplus_charger_switch - surplus-driven charger control
// Input register, single-pass step logic and result register.
// ----------------------------------------------------------------------------
// One measurement is accepted per clock while the step is not stalled, and
// each gives one result: it waits in the input register, then the step logic
// (charger rules, band lookups, car counters) writes the state and the result
// register together. A held result stalls the step, and a full input
// register then takes nothing. Configuration writes are taken every cycle.
module solar_surplus_charger_switch (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] net_power_i,
  input  logic [31:0]        time_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               fixed_on_o,
  output logic               regulated_on_o,
  output logic [9:0]         duty_level_o,
  output logic               duty_written_o,
  output logic               car_start_req_o,
  output logic               car_stop_req_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [ssc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import ssc_pkg::*;

  ssc_cfg_t        cfg_q, cfg_d;
  ssc_meas_t       meas_q;
  logic            in_vld_q, out_vld_q;
  logic            step;
  ssc_chg_status_t stat, nxt;
  logic            written, start_req, stop_req;

  assign step        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || step;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgAutoEnable: cfg_d.auto_enable     = cfg_data_i[0];
        CfgCarCtrl:    cfg_d.car_ctrl_enable = cfg_data_i[0];
        CfgCarStartW:  cfg_d.car_start_watts = cfg_data_i[15:0];
        CfgCarStopW:   cfg_d.car_stop_watts  = cfg_data_i[15:0];
        CfgS1RestMs:   cfg_d.s1_rest_ms      = cfg_data_i;
        CfgS2RestMs:   cfg_d.s2_rest_ms      = cfg_data_i;
        CfgCarGapMs:   cfg_d.car_gap_ms      = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auto_enable     <= 1'b1;
      cfg_q.car_ctrl_enable <= 1'b0;
      cfg_q.car_start_watts <= 16'sd500;
      cfg_q.car_stop_watts  <= -16'sd1000;
      cfg_q.s1_rest_ms      <= 32'd60000;
      cfg_q.s2_rest_ms      <= 32'd60000;
      cfg_q.car_gap_ms      <= 32'd600000;
      in_vld_q              <= 1'b0;
      out_vld_q             <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      if (in_valid_i && in_ready_o) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      meas_q.net_power <= net_power_i;
      meas_q.time_ms   <= time_ms_i;
    end
    if (step) begin
      fixed_on_o      <= nxt.fixed_on;
      regulated_on_o  <= nxt.regulated_on;
      duty_level_o    <= nxt.duty;
      duty_written_o  <= written;
      car_start_req_o <= start_req;
      car_stop_req_o  <= stop_req;
    end
  end

  assign out_valid_o = out_vld_q;

  ssc_charge u_charge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .meas_i    (meas_q),
    .cfg_i     (cfg_q),
    .stat_o    (stat),
    .next_o    (nxt),
    .written_o (written)
  );

  ssc_car u_car (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .meas_i      (meas_q),
    .cfg_i       (cfg_q),
    .chg_i       (stat),
    .start_req_o (start_req),
    .stop_req_o  (stop_req)
  );

endmodule

@@ hw/rtl/ssc_checker.sv @@
// ----------------------------------------------------------------------------
// ssc_checker - port-level checks
// Result consistency and output hold behaviour, bound to the top level.
// ----------------------------------------------------------------------------
module ssc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       regulated_on_o,
  input logic [9:0] duty_level_o,
  input logic       duty_written_o,
  input logic       car_start_req_o,
  input logic       car_stop_req_o
);

  // a new duty only while the regulated charger runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && duty_written_o |-> regulated_on_o)
    else $error("duty written with regulated charger off");

  // start and stop never requested in the same transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(car_start_req_o && car_stop_req_o))
    else $error("car start and stop requested together");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(duty_level_o))
    else $error("stalled result changed");

endmodule

bind solar_surplus_charger_switch ssc_checker u_ssc_checker (.*);

@@ dv/charger_step_checker.sv @@
// ----------------------------------------------------------------------------
// charger_step_checker - result checker for the solar surplus charger switch
// Follows configuration writes and measurement transfers, works out each
// charger status and compares it field by field with the next result
// transfer. Reports the mismatch count and the results still outstanding.
// ----------------------------------------------------------------------------
module charger_step_checker
  import ssc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic signed [15:0]  net_power_i,
  input  logic [31:0]         time_ms_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                fixed_on_i,
  input  logic                regulated_on_i,
  input  logic [9:0]          duty_level_i,
  input  logic                duty_written_i,
  input  logic                car_start_req_i,
  input  logic                car_stop_req_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output int                  mismatch_cnt_o,
  output int                  outstanding_o
);

  typedef struct packed {
    logic       fixed_on;
    logic       regulated_on;
    logic [9:0] duty;
    logic       written;
    logic       car_start;
    logic       car_stop;
  } charger_result_t;

  charger_result_t expected_status_q [$];
  charger_result_t want_res;
  charger_result_t next_res;
  int              mismatches = 0;

  ssc_cfg_t    settings;
  logic        fixed_st, regulated_st, car_charging;
  logic [9:0]  duty;
  logic        fixed_sw_seen, reg_sw_seen, fixed_low_run, reg_low_run, excess_run;
  logic [31:0] fixed_sw_ms, reg_sw_ms, fixed_low_ms, reg_low_ms, excess_ms;
  logic [31:0] last_car_ms;
  int          high_cnt, low_cnt;

  task automatic compare_field(input string name, input logic [9:0] want,
                               input logic [9:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic step_charger_model(input logic signed [15:0] np,
                                    input logic [31:0] now,
                                    output charger_result_t res);
    int          n, orig, avail, est, s;
    logic        s1, s2, done;
    logic [31:0] now_off;
    n = np;
    orig = np;
    s1 = fixed_st;
    s2 = regulated_st;
    done = 1'b0;
    res = '0;
    now_off = now + settings.car_gap_ms;

    // car requests
    if (now_off - last_car_ms > settings.car_gap_ms) begin
      if (s1 && s2 && duty == DutyMax && orig > int'($signed(settings.car_start_watts)) &&
          !car_charging) begin
        if (high_cnt >= 10 && settings.car_ctrl_enable) begin
          res.car_start = 1'b1;
          last_car_ms = now_off;
          car_charging = 1'b1;
          high_cnt = 0;
        end else if (high_cnt < 15) begin
          high_cnt++;
        end
      end else if (orig < int'($signed(settings.car_stop_watts)) && car_charging &&
                   settings.car_ctrl_enable) begin
        if (low_cnt >= 10) begin
          res.car_stop = 1'b1;
          last_car_ms = now_off;
          car_charging = 1'b0;
          low_cnt = 0;
        end else begin
          low_cnt++;
        end
      end
    end

    if (settings.auto_enable) begin
      // fixed charger
      if ((!s1 && n > 600) || (s1 && n > 0)) fixed_low_run = 1'b0;
      if (!fixed_sw_seen || now - fixed_sw_ms > settings.s1_rest_ms) begin
        if (!s1) begin
          if (duty < 10'd50) est = 0;
          else if (duty < 10'd100) est = 100;
          else if (duty < 10'd950) est = 100 + 50 * (int'(duty) / 100);
          else est = 600;
          avail = s2 ? n + est : n;
          if (avail > 600) begin
            if (!excess_run) begin
              excess_run = 1'b1;
              excess_ms = now;
            end
            if (now - excess_ms > 32'd60000) begin
              n -= 600;
              s1 = 1'b1;
              fixed_st = 1'b1;
              fixed_sw_seen = 1'b1;
              fixed_sw_ms = now;
              if (s2) done = 1'b1;
            end
          end else begin
            excess_run = 1'b0;
          end
        end else if (n < -300) begin
          if (!fixed_low_run) begin
            fixed_low_run = 1'b1;
            fixed_low_ms = now;
          end
          if (now - fixed_low_ms > 32'd60000) begin
            n += 600;
            s1 = 1'b0;
            fixed_st = 1'b0;
            excess_run = 1'b0;
            fixed_sw_seen = 1'b1;
            fixed_sw_ms = now;
          end
        end
      end

      // regulated charger
      if (!done) begin
        if (n > 0) reg_low_run = 1'b0;
        if (!reg_sw_seen || now - reg_sw_ms > settings.s2_rest_ms) begin
          if (!s2) begin
            if (n > 30) begin
              s2 = 1'b1;
              regulated_st = 1'b1;
              reg_sw_seen = 1'b1;
              reg_sw_ms = now;
              done = 1'b1;
            end
          end else if (n < -100) begin
            if (!reg_low_run) begin
              reg_low_run = 1'b1;
              reg_low_ms = now;
            end
            if (now - reg_low_ms > 32'd300000) begin
              s2 = 1'b0;
              regulated_st = 1'b0;
              reg_sw_seen = 1'b1;
              reg_sw_ms = now;
            end
          end
        end
      end
    end

    // duty bands: 0 below 100, then hundreds plus 20, 980 up to 1100, else full
    if (!done && s2) begin
      s = 2 * n + int'(duty);
      if (s >= 1100) duty = DutyMax;
      else if (s < 100) duty = 10'd0;
      else if (s >= 1000) duty = 10'd980;
      else duty = 10'((s / 100) * 100 + 20);
      res.written = 1'b1;
    end

    res.fixed_on = fixed_st;
    res.regulated_on = regulated_st;
    res.duty = duty;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings.auto_enable = 1'b1;
      settings.car_ctrl_enable = 1'b0;
      settings.car_start_watts = 16'sd500;
      settings.car_stop_watts = -16'sd1000;
      settings.s1_rest_ms = 32'd60000;
      settings.s2_rest_ms = 32'd60000;
      settings.car_gap_ms = 32'd600000;
      fixed_st = 1'b0;
      regulated_st = 1'b0;
      car_charging = 1'b0;
      duty = '0;
      fixed_sw_seen = 1'b0;
      reg_sw_seen = 1'b0;
      fixed_low_run = 1'b0;
      reg_low_run = 1'b0;
      excess_run = 1'b0;
      fixed_sw_ms = '0;
      reg_sw_ms = '0;
      fixed_low_ms = '0;
      reg_low_ms = '0;
      excess_ms = '0;
      last_car_ms = '0;
      high_cnt = 0;
      low_cnt = 0;
      expected_status_q.delete();
      outstanding_o <= 0;
      mismatch_cnt_o <= mismatches;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_status_q.size() == 0) begin
          $error("result transfer with no status outstanding");
          mismatches++;
        end else begin
          want_res = expected_status_q.pop_front();
          compare_field("fixed_on", want_res.fixed_on, fixed_on_i);
          compare_field("regulated_on", want_res.regulated_on, regulated_on_i);
          compare_field("duty_level", want_res.duty, duty_level_i);
          compare_field("duty_written", want_res.written, duty_written_i);
          compare_field("car_start_req", want_res.car_start, car_start_req_i);
          compare_field("car_stop_req", want_res.car_stop, car_stop_req_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        step_charger_model(net_power_i, time_ms_i, next_res);
        expected_status_q.push_back(next_res);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgAutoEnable: settings.auto_enable = cfg_data_i[0];
          CfgCarCtrl:    settings.car_ctrl_enable = cfg_data_i[0];
          CfgCarStartW:  settings.car_start_watts = cfg_data_i[15:0];
          CfgCarStopW:   settings.car_stop_watts = cfg_data_i[15:0];
          CfgS1RestMs:   settings.s1_rest_ms = cfg_data_i;
          CfgS2RestMs:   settings.s2_rest_ms = cfg_data_i;
          CfgCarGapMs:   settings.car_gap_ms = cfg_data_i;
          default: ;
        endcase
      end
      outstanding_o <= expected_status_q.size();
      mismatch_cnt_o <= mismatches;
    end
  end

endmodule

@@ dv/solar_surplus_charger_switch_test.sv @@
// ----------------------------------------------------------------------------
// solar_surplus_charger_switch_test - top level testbench
// Drives a directed run of boundary measurements, then phases of random
// supply profiles under changing settings, with bursty input, a receiver
// that stalls on its own pattern and long receiver hold-offs. The checker
// beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module solar_surplus_charger_switch_test;
  import ssc_pkg::*;

  localparam int PhaseCount    = 10;
  localparam int ItemsPerPhase = 153;
  localparam int DirectedCount = 20;
  localparam int LongHold      = 400;
  localparam int CycleLimit    = 600000;

  localparam logic [CfgIdxW-1:0] CfgSpare = 3'd7;

  typedef enum logic [2:0] {
    SupplyStrong, SupplyMild, SupplyFlat, SupplyShort, SupplyDeep, SupplyNoise
  } supply_mode_e;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic signed [15:0]  net_power_i = '0;
  logic [31:0]         time_ms_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                fixed_on_o;
  logic                regulated_on_o;
  logic [9:0]          duty_level_o;
  logic                duty_written_o;
  logic                car_start_req_o;
  logic                car_stop_req_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [31:0]         cfg_data_i = '0;

  int mismatch_cnt;
  int outstanding;
  int hold_requests = 0;
  int holds_done = 0;
  int cycle_cnt = 0;

  solar_surplus_charger_switch DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .net_power_i     (net_power_i),
    .time_ms_i       (time_ms_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .fixed_on_o      (fixed_on_o),
    .regulated_on_o  (regulated_on_o),
    .duty_level_o    (duty_level_o),
    .duty_written_o  (duty_written_o),
    .car_start_req_o (car_start_req_o),
    .car_stop_req_o  (car_stop_req_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  charger_step_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .net_power_i     (net_power_i),
    .time_ms_i       (time_ms_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .fixed_on_i      (fixed_on_o),
    .regulated_on_i  (regulated_on_o),
    .duty_level_i    (duty_level_o),
    .duty_written_i  (duty_written_o),
    .car_start_req_i (car_start_req_o),
    .car_stop_req_i  (car_stop_req_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mismatch_cnt_o  (mismatch_cnt),
    .outstanding_o   (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[solar_surplus_charger_switch] ERROR");
    $finish;
  end

  task automatic send_measurement(input logic signed [15:0] np, input logic [31:0] stamp);
    in_valid_i <= 1'b1;
    net_power_i <= np;
    time_ms_i <= stamp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // value stays on the bus; the caller drops cfg_valid_i after the last write
  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_span();
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return $urandom_range(1, 5000);
      2:       return 32'd60000;
      3:       return $urandom_range(60000, 700000);
      default: return $urandom;
    endcase
  endfunction

  // receiver: random ready pattern, plus a long hold-off when asked
  initial begin
    int mode;
    int span;
    int hold_cnt;
    @(posedge clk_i);
    forever begin
      if (hold_requests > holds_done) begin
        holds_done++;
        for (hold_cnt = 0; hold_cnt < LongHold; hold_cnt++) begin
          out_ready_i <= 1'b0;
          @(posedge clk_i);
        end
      end else begin
        mode = $urandom_range(0, 4);
        span = $urandom_range(1, 30);
        repeat (span) begin
          case (mode)
            0, 1:    out_ready_i <= 1'b1;
            2, 3:    out_ready_i <= 1'($urandom_range(0, 1));
            default: out_ready_i <= ($urandom_range(0, 7) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    logic signed [15:0] dir_net [DirectedCount];
    logic [31:0]        dir_ms [DirectedCount];
    logic               auto_en, car_en;
    logic [15:0]        start_w, stop_w;
    logic [31:0]        rest1, rest2, gap_ms;
    logic [31:0]        now_ms;
    logic signed [15:0] np;
    supply_mode_e       mode;
    int                 mode_left, left, burst, gap, phase_idx;

    // thresholds, early finishes, timer edges and timestamp wrap
    dir_net = '{16'sd0, 16'sd30, 16'sd31, 16'sd32767, -16'sd32768, 16'sd601, 16'sd601,
                16'sd601, 16'sd600, -16'sd300, -16'sd301, -16'sd301, -16'sd301,
                -16'sd100, -16'sd101, -16'sd101, -16'sd101, -16'sd1, 16'sd32767,
                -16'sd32768};
    dir_ms = '{32'd0, 32'd500, 32'd1000, 32'd2000, 32'd3000, 32'd4000, 32'd64000,
               32'd64001, 32'd70000, 32'd80000, 32'd130000, 32'd190000, 32'd190001,
               32'd200000, 32'd260000, 32'd560000, 32'd560001, 32'hFFFF_FFF0,
               32'h0000_0010, 32'h0000_0020};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirectedCount; i++) send_measurement(dir_net[i], dir_ms[i]);
    in_valid_i <= 1'b0;
    now_ms = 32'h0000_0020;

    for (phase_idx = 0; phase_idx < PhaseCount; phase_idx++) begin
      do @(posedge clk_i); while (outstanding != 0);
      repeat (4) @(posedge clk_i);

      case (phase_idx)
        0: begin
          auto_en = 1'b1; car_en = 1'b1; start_w = 16'd500; stop_w = -16'sd1000;
          rest1 = 32'd0; rest2 = 32'd0; gap_ms = 32'd0;
        end
        1: begin
          auto_en = 1'b1; car_en = 1'b1; start_w = 16'h8000; stop_w = 16'h7FFF;
          rest1 = 32'd60000; rest2 = 32'd60000; gap_ms = 32'd1000;
        end
        2: begin
          auto_en = 1'b0; car_en = 1'b1; start_w = 16'h7FFF; stop_w = 16'h8000;
          rest1 = '1; rest2 = '1; gap_ms = '1;
        end
        default: begin
          auto_en = ($urandom_range(0, 4) != 0);
          car_en = 1'($urandom_range(0, 1));
          start_w = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
          stop_w = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                              : 16'(-$urandom_range(0, 3000));
          rest1 = pick_span();
          rest2 = pick_span();
          gap_ms = pick_span();
        end
      endcase
      write_cfg(CfgAutoEnable, {31'($urandom), auto_en});
      write_cfg(CfgCarCtrl, {31'($urandom), car_en});
      write_cfg(CfgCarStartW, {16'($urandom), start_w});
      write_cfg(CfgCarStopW, {16'($urandom), stop_w});
      write_cfg(CfgS1RestMs, rest1);
      write_cfg(CfgS2RestMs, rest2);
      write_cfg(CfgCarGapMs, gap_ms);
      if (phase_idx % 2 == 1) write_cfg(CfgSpare, $urandom);
      cfg_valid_i <= 1'b0;

      // receiver holds off while the sender keeps offering
      if (phase_idx == 1 || phase_idx == 6) hold_requests <= hold_requests + 1;
      if (phase_idx % 4 == 3) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 300000);

      left = ItemsPerPhase;
      mode_left = 0;
      while (left > 0) begin
        burst = $urandom_range(1, 24);
        while (burst > 0 && left > 0) begin
          if (mode_left == 0) begin
            case ($urandom_range(0, 9))
              0, 1, 2: mode = SupplyStrong;
              3:       mode = SupplyMild;
              4:       mode = SupplyFlat;
              5:       mode = SupplyShort;
              6, 7:    mode = SupplyDeep;
              default: mode = SupplyNoise;
            endcase
            mode_left = $urandom_range(5, 40);
          end
          case (mode)
            SupplyStrong: np = 16'($urandom_range(601, 4000));
            SupplyMild:   np = 16'($urandom_range(31, 600));
            SupplyFlat:   np = 16'($urandom_range(0, 130) - 100);
            SupplyShort:  np = 16'(-$urandom_range(101, 300));
            SupplyDeep:   np = 16'(-$urandom_range(301, 3000));
            default:      np = 16'($urandom);
          endcase
          if ($urandom_range(0, 11) == 0) np = 16'($urandom);
          case ($urandom_range(0, 19))
            0:       now_ms = now_ms + $urandom;
            1, 2:    now_ms = now_ms + $urandom_range(0, 999);
            3:       now_ms = now_ms + $urandom_range(60000, 400000);
            default: now_ms = now_ms + $urandom_range(1000, 20000);
          endcase
          send_measurement(np, now_ms);
          burst--;
          left--;
          mode_left--;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (left > 0 && gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      in_valid_i <= 1'b0;
    end

    do @(posedge clk_i); while (outstanding != 0);
    repeat (6) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("[solar_surplus_charger_switch] OK");
    end else begin
      $display("[solar_surplus_charger_switch] ERROR");
    end
    $finish;
  end

endmodule
